[rtl/core/svr_pkg.sv]
// Shared types, constants and helpers for the stereo vocal removal biquad block.
// No dependencies; used by svr_dp, svr_ctrl, svr_chk and the top level by scoped names.
package svr_pkg;

  localparam int unsigned SmpW       = 16;
  localparam int unsigned CoefW      = 16;
  localparam int unsigned DlyW       = 32;
  localparam int unsigned ProdW      = DlyW + CoefW;
  localparam int unsigned SumW       = DlyW + 2;
  localparam int unsigned GainW      = 8;
  localparam int unsigned ScaleW     = SumW + GainW + 1;
  localparam int unsigned QShift     = 15;
  localparam int unsigned CoefPerSec = 5;
  localparam int unsigned DlyPerSec  = 2;
  localparam int unsigned SecW       = 3;
  localparam int unsigned SlotW      = 3;
  localparam int unsigned SecCmpW    = SecW + 2;

  localparam logic [GainW-1:0] GainRst = 8'd10;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  localparam logic BANK_LP = 1'b0;
  localparam logic BANK_HP = 1'b1;

  localparam logic [SlotW-1:0] SLOT_B0 = 3'd0;
  localparam logic [SlotW-1:0] SLOT_B1 = 3'd1;
  localparam logic [SlotW-1:0] SLOT_B2 = 3'd2;
  localparam logic [SlotW-1:0] SLOT_A1 = 3'd3;
  localparam logic [SlotW-1:0] SLOT_A2 = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_LP_L,
    PH_LP_R,
    PH_HP_L,
    PH_HP_R
  } phase_e;

  // one biquad section pass, one channel
  typedef enum logic [2:0] {
    STP_LD,
    STP_A1,
    STP_A2,
    STP_W,
    STP_B1,
    STP_B2,
    STP_Y
  } step_e;

  typedef enum logic [1:0] {
    OPD_RAM,
    OPD_D0,
    OPD_D1,
    OPD_W
  } opd_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_XSUB,
    ACC_SUB,
    ACC_SET,
    ACC_ADD
  } acc_e;

  typedef struct packed {
    opd_e   opd_sel;
    acc_e   acc_op;
    logic   cap_d0;
    logic   cap_d1;
    logic   cap_w;
    logic   ld_in;
    logic   sec_end;
    logic   last_sec;
    logic   fin;
    logic   wr_d1;
    phase_e phase;
  } dp_ctrl_t;

  function automatic logic signed [SmpW-1:0] sat16(input logic signed [ScaleW-1:0] v);
    logic signed [ScaleW-1:0] hi;
    logic signed [ScaleW-1:0] lo;
    logic signed [SmpW-1:0]   r;
    hi = {{(ScaleW-SmpW+1){1'b0}}, {(SmpW-1){1'b1}}};
    lo = {{(ScaleW-SmpW+1){1'b1}}, {(SmpW-1){1'b0}}};
    if (v > hi) begin
      r = hi[SmpW-1:0];
    end else if (v < lo) begin
      r = lo[SmpW-1:0];
    end else begin
      r = v[SmpW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/svr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the coefficient and delay stores.
module svr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/svr_dp.sv]
// Datapath: shared 32x16 multiplier with Q15 shift and accumulator, section
// operand registers, cascade results, final mix, gain and saturation. Uses svr_pkg.
module svr_dp (
  input  logic                                clk_i,
  input  svr_pkg::dp_ctrl_t                   ctrl_i,
  input  logic signed [svr_pkg::CoefW-1:0]    coef_i,
  input  logic signed [svr_pkg::DlyW-1:0]     dly_i,
  input  logic signed [svr_pkg::SmpW-1:0]     left_i,
  input  logic signed [svr_pkg::SmpW-1:0]     right_i,
  input  logic        [svr_pkg::GainW-1:0]    gain_i,
  output logic        [svr_pkg::DlyW-1:0]     dly_wdata_o,
  output logic signed [svr_pkg::SmpW-1:0]     left_o,
  output logic signed [svr_pkg::SmpW-1:0]     right_o
);

  localparam int unsigned DlyW = svr_pkg::DlyW;
  localparam int unsigned SumW = svr_pkg::SumW;

  logic signed [DlyW-1:0]           opd;
  logic signed [svr_pkg::ProdW-1:0] prod_d, prod_q;
  logic signed [DlyW-1:0]           pq;
  logic signed [DlyW-1:0]           acc_d, acc_q;
  logic signed [DlyW-1:0]           y;
  logic signed [DlyW-1:0]           d0_q, d1_q, w_q;
  logic signed [DlyW-1:0]           x_q, smp_r_q;
  logic signed [DlyW-1:0]           lp_l_q, lp_r_q, hp_l_q, hp_r_q;
  logic signed [SumW-1:0]           sum_l_q, sum_r_q;
  logic signed [svr_pkg::ScaleW-1:0] scl_l, scl_r;
  logic signed [svr_pkg::GainW:0]    gain_s;

  always_comb begin
    unique case (ctrl_i.opd_sel)
      svr_pkg::OPD_RAM: opd = dly_i;
      svr_pkg::OPD_D0:  opd = d0_q;
      svr_pkg::OPD_D1:  opd = d1_q;
      svr_pkg::OPD_W:   opd = w_q;
    endcase
  end

  assign prod_d = coef_i * opd;
  // floor shift by 15, wrapped to 32 bits
  assign pq = $signed(prod_q[svr_pkg::QShift+DlyW-1:svr_pkg::QShift]);
  assign y  = acc_q + pq;

  always_comb begin
    unique case (ctrl_i.acc_op)
      svr_pkg::ACC_XSUB: acc_d = x_q - pq;
      svr_pkg::ACC_SUB:  acc_d = acc_q - pq;
      svr_pkg::ACC_SET:  acc_d = pq;
      svr_pkg::ACC_ADD:  acc_d = acc_q + pq;
      default:           acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (ctrl_i.cap_d0) begin
      d0_q <= dly_i;
    end
    if (ctrl_i.cap_d1) begin
      d1_q <= dly_i;
    end
    if (ctrl_i.cap_w) begin
      w_q <= acc_q;
    end
    if (ctrl_i.ld_in) begin
      x_q     <= DlyW'(left_i);
      smp_r_q <= DlyW'(right_i);
    end else if (ctrl_i.sec_end) begin
      if (ctrl_i.last_sec) begin
        unique case (ctrl_i.phase)
          svr_pkg::PH_LP_L: begin
            lp_l_q <= y;
            x_q    <= smp_r_q;
          end
          svr_pkg::PH_LP_R: begin
            lp_r_q <= y;
            x_q    <= lp_l_q;
          end
          svr_pkg::PH_HP_L: begin
            hp_l_q <= y;
            x_q    <= lp_r_q;
          end
          svr_pkg::PH_HP_R: begin
            hp_r_q <= y;
          end
        endcase
      end else begin
        x_q <= y;
      end
    end
    if (ctrl_i.fin) begin
      sum_l_q <= SumW'(hp_l_q) - SumW'(hp_r_q) + SumW'(lp_l_q);
      sum_r_q <= SumW'(hp_r_q) - SumW'(hp_l_q) + SumW'(lp_r_q);
    end
  end

  assign gain_s = $signed({1'b0, gain_i});
  assign scl_l  = sum_l_q * gain_s;
  assign scl_r  = sum_r_q * gain_s;

  assign left_o      = svr_pkg::sat16(scl_l);
  assign right_o     = svr_pkg::sat16(scl_r);
  assign dly_wdata_o = ctrl_i.wr_d1 ? d0_q : acc_q;

endmodule

[rtl/core/svr_ctrl.sv]
// Sequencer: walks sections, channels and cascades, drives the shared datapath
// and the coefficient and delay store addresses. Uses svr_pkg.
module svr_ctrl #(
  parameter int unsigned LOW_SECTIONS  = 8,
  parameter int unsigned HIGH_SECTIONS = 8
) (
  input  logic                                                         clk_i,
  input  logic                                                         rst_ni,
  input  logic                                                         in_valid_i,
  input  logic                                                         mode_i,
  input  logic                                                         out_free_i,
  output logic                                                         in_stall_o,
  output logic                                                         out_load_o,
  output svr_pkg::dp_ctrl_t                                            dp_ctrl_o,
  output logic [$clog2(svr_pkg::CoefPerSec*(LOW_SECTIONS+HIGH_SECTIONS))-1:0] coef_raddr_o,
  output logic [$clog2(svr_pkg::DlyPerSec*2*(LOW_SECTIONS+HIGH_SECTIONS))-1:0] dly_raddr_o,
  output logic [$clog2(svr_pkg::DlyPerSec*2*(LOW_SECTIONS+HIGH_SECTIONS))-1:0] dly_waddr_o,
  output logic                                                         dly_we_o
);

  localparam int unsigned CoefDepth = svr_pkg::CoefPerSec * (LOW_SECTIONS + HIGH_SECTIONS);
  localparam int unsigned DlyDepth  = svr_pkg::DlyPerSec * 2 * (LOW_SECTIONS + HIGH_SECTIONS);
  localparam int unsigned CAW       = $clog2(CoefDepth);
  localparam int unsigned DAW       = $clog2(DlyDepth);
  localparam int unsigned MaxSec    = (LOW_SECTIONS > HIGH_SECTIONS) ? LOW_SECTIONS
                                                                     : HIGH_SECTIONS;
  localparam int unsigned SCW       = $clog2(MaxSec + 1);
  localparam logic [CAW-1:0] HpBase = CAW'(svr_pkg::CoefPerSec * LOW_SECTIONS);

  svr_pkg::state_e state_d, state_q;
  svr_pkg::step_e  step_d, step_q;
  svr_pkg::phase_e phase_d, phase_q;
  logic [SCW-1:0]  sec_d, sec_q;
  logic [CAW-1:0]  coef_base_d, coef_base_q;
  logic [DAW-1:0]  dly_base_d, dly_base_q;
  logic            start;
  logic            last_sec;
  logic            item_end;
  logic [svr_pkg::SlotW-1:0] slot;

  assign start    = in_valid_i && (state_q == svr_pkg::ST_IDLE) &&
                    (mode_i == svr_pkg::MODE_SAMPLE);
  assign last_sec = (phase_q == svr_pkg::PH_LP_L || phase_q == svr_pkg::PH_LP_R) ?
                    (sec_q == SCW'(LOW_SECTIONS - 1)) : (sec_q == SCW'(HIGH_SECTIONS - 1));
  assign item_end = (step_q == svr_pkg::STP_Y) && last_sec && (phase_q == svr_pkg::PH_HP_R);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      svr_pkg::ST_IDLE: if (start) state_d = svr_pkg::ST_RUN;
      svr_pkg::ST_RUN:  if (item_end) state_d = svr_pkg::ST_FIN;
      svr_pkg::ST_FIN:  state_d = svr_pkg::ST_OUT;
      svr_pkg::ST_OUT:  if (out_free_i) state_d = svr_pkg::ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    step_d      = step_q;
    phase_d     = phase_q;
    sec_d       = sec_q;
    coef_base_d = coef_base_q;
    dly_base_d  = dly_base_q;
    if (start) begin
      step_d      = svr_pkg::STP_LD;
      phase_d     = svr_pkg::PH_LP_L;
      sec_d       = '0;
      coef_base_d = '0;
      dly_base_d  = '0;
    end else if (state_q == svr_pkg::ST_RUN) begin
      unique case (step_q)
        svr_pkg::STP_LD: step_d = svr_pkg::STP_A1;
        svr_pkg::STP_A1: step_d = svr_pkg::STP_A2;
        svr_pkg::STP_A2: step_d = svr_pkg::STP_W;
        svr_pkg::STP_W:  step_d = svr_pkg::STP_B1;
        svr_pkg::STP_B1: step_d = svr_pkg::STP_B2;
        svr_pkg::STP_B2: step_d = svr_pkg::STP_Y;
        default:         step_d = svr_pkg::STP_LD;
      endcase
      if (step_q == svr_pkg::STP_Y && !item_end) begin
        dly_base_d = dly_base_q + DAW'(svr_pkg::DlyPerSec);
        if (last_sec) begin
          sec_d       = '0;
          coef_base_d = (phase_q == svr_pkg::PH_LP_L) ? '0 : HpBase;
          unique case (phase_q)
            svr_pkg::PH_LP_L: phase_d = svr_pkg::PH_LP_R;
            svr_pkg::PH_LP_R: phase_d = svr_pkg::PH_HP_L;
            svr_pkg::PH_HP_L: phase_d = svr_pkg::PH_HP_R;
            svr_pkg::PH_HP_R: phase_d = svr_pkg::PH_LP_L;
          endcase
        end else begin
          sec_d       = sec_q + SCW'(1);
          coef_base_d = coef_base_q + CAW'(svr_pkg::CoefPerSec);
        end
      end
    end
  end

  // outputs
  always_comb begin
    dp_ctrl_o          = '0;
    dp_ctrl_o.opd_sel  = svr_pkg::OPD_RAM;
    dp_ctrl_o.acc_op   = svr_pkg::ACC_HOLD;
    dp_ctrl_o.phase    = phase_q;
    dp_ctrl_o.last_sec = last_sec;
    dp_ctrl_o.ld_in    = start;
    dp_ctrl_o.fin      = (state_q == svr_pkg::ST_FIN);
    dly_we_o           = 1'b0;
    dly_waddr_o        = dly_base_q;
    slot               = svr_pkg::SLOT_B0;
    if (state_q == svr_pkg::ST_RUN) begin
      unique case (step_q)
        svr_pkg::STP_LD: begin
          slot = svr_pkg::SLOT_A1;
        end
        svr_pkg::STP_A1: begin
          slot             = svr_pkg::SLOT_A2;
          dp_ctrl_o.cap_d0 = 1'b1;
        end
        svr_pkg::STP_A2: begin
          slot             = svr_pkg::SLOT_B1;
          dp_ctrl_o.cap_d1 = 1'b1;
          dp_ctrl_o.acc_op = svr_pkg::ACC_XSUB;
        end
        svr_pkg::STP_W: begin
          slot              = svr_pkg::SLOT_B2;
          dp_ctrl_o.opd_sel = svr_pkg::OPD_D0;
          dp_ctrl_o.acc_op  = svr_pkg::ACC_SUB;
        end
        svr_pkg::STP_B1: begin
          slot              = svr_pkg::SLOT_B0;
          dp_ctrl_o.opd_sel = svr_pkg::OPD_D1;
          dp_ctrl_o.acc_op  = svr_pkg::ACC_SET;
          dp_ctrl_o.cap_w   = 1'b1;
          dly_we_o          = 1'b1;
        end
        svr_pkg::STP_B2: begin
          dp_ctrl_o.opd_sel = svr_pkg::OPD_W;
          dp_ctrl_o.acc_op  = svr_pkg::ACC_ADD;
          dp_ctrl_o.wr_d1   = 1'b1;
          dly_we_o          = 1'b1;
          dly_waddr_o       = dly_base_q + DAW'(1);
        end
        default: begin
          dp_ctrl_o.sec_end = 1'b1;
        end
      endcase
    end
  end

  assign coef_raddr_o = coef_base_q + CAW'(slot);
  assign dly_raddr_o  = dly_base_q + DAW'(step_q == svr_pkg::STP_A1);
  assign in_stall_o   = (state_q != svr_pkg::ST_IDLE);
  assign out_load_o   = (state_q == svr_pkg::ST_OUT) && out_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svr_pkg::ST_IDLE;
      step_q      <= svr_pkg::STP_LD;
      phase_q     <= svr_pkg::PH_LP_L;
      sec_q       <= '0;
      coef_base_q <= '0;
      dly_base_q  <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      sec_q       <= sec_d;
      coef_base_q <= coef_base_d;
      dly_base_q  <= dly_base_d;
    end
  end

endmodule

[rtl/core/stereo_vocal_removal_biquad.sv]
// Top level of the stereo vocal removal biquad block: coefficient and delay
// stores, gain register and output register. Uses svr_pkg, svr_ram, svr_dp, svr_ctrl.
//
// Channel  Handshake                Payload
// in       in_valid_i / in_stall_o  mode_i, left_in_i, right_in_i, coef_bank_i,
//                                   coef_section_i, coef_slot_i, coef_value_i
// out      out_valid_o / out_stall_i left_out_o, right_out_o
// cfg      cfg_we_i                 cfg_wdata_i (output gain)
//
// A sample pair keeps the input stalled until its result is taken into the output
// register; each section of each channel runs in turn on the one 32x16 multiplier.
// A coefficient write is taken while the input is not stalled and gives no result.
// Reset sets gain to 10 and marks all coefficient and delay words as zero.
// The result sits in an output register; the core only waits at the end of
// an item if the previous result is still stalled.
module stereo_vocal_removal_biquad #(
  parameter int unsigned LOW_SECTIONS  = 8,
  parameter int unsigned HIGH_SECTIONS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 mode_i,
  input  logic signed [svr_pkg::SmpW-1:0]      left_in_i,
  input  logic signed [svr_pkg::SmpW-1:0]      right_in_i,
  input  logic                                 coef_bank_i,
  input  logic        [svr_pkg::SecW-1:0]      coef_section_i,
  input  logic        [svr_pkg::SlotW-1:0]     coef_slot_i,
  input  logic signed [svr_pkg::CoefW-1:0]     coef_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [svr_pkg::SmpW-1:0]      left_out_o,
  output logic signed [svr_pkg::SmpW-1:0]      right_out_o,
  input  logic                                 cfg_we_i,
  input  logic        [svr_pkg::GainW-1:0]     cfg_wdata_i
);

  localparam int unsigned CoefDepth = svr_pkg::CoefPerSec * (LOW_SECTIONS + HIGH_SECTIONS);
  localparam int unsigned DlyDepth  = svr_pkg::DlyPerSec * 2 * (LOW_SECTIONS + HIGH_SECTIONS);
  localparam int unsigned CAW       = $clog2(CoefDepth);
  localparam int unsigned DAW       = $clog2(DlyDepth);
  localparam int unsigned SecCmpW   = svr_pkg::SecCmpW;
  localparam logic [CAW-1:0] HpBase = CAW'(svr_pkg::CoefPerSec * LOW_SECTIONS);

  svr_pkg::dp_ctrl_t              dp_ctrl;
  logic [svr_pkg::GainW-1:0]      gain_q;
  logic [CoefDepth-1:0]           coef_vld_q;
  logic [DlyDepth-1:0]            dly_vld_q;
  logic                           coef_rv_q, dly_rv_q;
  logic [CAW-1:0]                 coef_raddr, coef_waddr;
  logic [DAW-1:0]                 dly_raddr, dly_waddr;
  logic                           dly_we;
  logic                           coef_we;
  logic                           sec_ok;
  logic [svr_pkg::CoefW-1:0]      coef_rdata;
  logic [svr_pkg::DlyW-1:0]       dly_rdata, dly_wdata;
  logic signed [svr_pkg::CoefW-1:0] coef_m;
  logic signed [svr_pkg::DlyW-1:0]  dly_m;
  logic signed [svr_pkg::SmpW-1:0]  left_res, right_res;
  logic                           out_free, out_load;
  logic                           out_valid_q;
  logic signed [svr_pkg::SmpW-1:0]  left_out_q, right_out_q;

  assign sec_ok  = (coef_bank_i == svr_pkg::BANK_HP) ?
                   (SecCmpW'(coef_section_i) < SecCmpW'(HIGH_SECTIONS)) :
                   (SecCmpW'(coef_section_i) < SecCmpW'(LOW_SECTIONS));
  assign coef_we = in_valid_i && !in_stall_o && (mode_i == svr_pkg::MODE_COEF) &&
                   (coef_slot_i <= svr_pkg::SLOT_A2) && sec_ok;
  assign coef_waddr = ((coef_bank_i == svr_pkg::BANK_HP) ? HpBase : CAW'(0)) +
                      CAW'(coef_section_i) * CAW'(svr_pkg::CoefPerSec) + CAW'(coef_slot_i);

  svr_ctrl #(
    .LOW_SECTIONS (LOW_SECTIONS),
    .HIGH_SECTIONS(HIGH_SECTIONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .out_free_i  (out_free),
    .in_stall_o  (in_stall_o),
    .out_load_o  (out_load),
    .dp_ctrl_o   (dp_ctrl),
    .coef_raddr_o(coef_raddr),
    .dly_raddr_o (dly_raddr),
    .dly_waddr_o (dly_waddr),
    .dly_we_o    (dly_we)
  );

  svr_ram #(
    .WIDTH(svr_pkg::CoefW),
    .DEPTH(CoefDepth)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .waddr_i(coef_waddr),
    .wdata_i(coef_value_i),
    .raddr_i(coef_raddr),
    .rdata_o(coef_rdata)
  );

  svr_ram #(
    .WIDTH(svr_pkg::DlyW),
    .DEPTH(DlyDepth)
  ) u_dly_ram (
    .clk_i  (clk_i),
    .we_i   (dly_we),
    .waddr_i(dly_waddr),
    .wdata_i(dly_wdata),
    .raddr_i(dly_raddr),
    .rdata_o(dly_rdata)
  );

  // never-written words read as zero
  assign coef_m = coef_rv_q ? $signed(coef_rdata) : '0;
  assign dly_m  = dly_rv_q ? $signed(dly_rdata) : '0;

  svr_dp u_dp (
    .clk_i      (clk_i),
    .ctrl_i     (dp_ctrl),
    .coef_i     (coef_m),
    .dly_i      (dly_m),
    .left_i     (left_in_i),
    .right_i    (right_in_i),
    .gain_i     (gain_q),
    .dly_wdata_o(dly_wdata),
    .left_o     (left_res),
    .right_o    (right_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= svr_pkg::GainRst;
      coef_vld_q <= '0;
      dly_vld_q  <= '0;
      coef_rv_q  <= 1'b0;
      dly_rv_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (coef_we) begin
        coef_vld_q[coef_waddr] <= 1'b1;
      end
      if (dly_we) begin
        dly_vld_q[dly_waddr] <= 1'b1;
      end
      coef_rv_q <= coef_vld_q[coef_raddr];
      dly_rv_q  <= dly_vld_q[dly_raddr];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_out_q  <= left_res;
      right_out_q <= right_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule

[rtl/core/svr_chk.sv]
// Port-level checker for stereo_vocal_removal_biquad, attached by bind.
// Uses svr_pkg for the mode codes.
module svr_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic mode_i,
  input logic out_valid_o,
  input logic out_stall_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_smp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == svr_pkg::MODE_SAMPLE) |=> in_stall_o)
    else $error("sample transfer did not start processing");

  a_coef_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == svr_pkg::MODE_COEF) |=> !in_stall_o)
    else $error("coefficient transfer made the block busy");

  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a sample in progress");

endmodule

bind stereo_vocal_removal_biquad svr_chk u_svr_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .mode_i     (mode_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i)
);

[tb/sv/tb_stereo_vocal_removal_biquad.sv]
`timescale 1ns / 1ps
// Testbench for stereo_vocal_removal_biquad: a directed table, then random phases of coefficient
// loads and sample pairs, checked against a bit-exact model of the biquad cascades.
// Depends on svr_pkg and the stereo_vocal_removal_biquad RTL.
module tb_stereo_vocal_removal_biquad;

  localparam int LowSecs       = 8;
  localparam int HighSecs      = 8;
  localparam int ItemTarget    = 1550;
  localparam int SettleCycles  = 12;
  localparam int WatchdogLimit = 5000;
  localparam int ReportMax     = 10;
  localparam longint SmpMax    = 32767;
  localparam longint SmpMin    = -32768;

  typedef struct packed {
    logic                             mode;
    logic signed [svr_pkg::SmpW-1:0]  left;
    logic signed [svr_pkg::SmpW-1:0]  right;
    logic                             bank;
    logic [svr_pkg::SecW-1:0]         section;
    logic [svr_pkg::SlotW-1:0]        slot;
    logic signed [svr_pkg::CoefW-1:0] value;
  } stim_t;

  typedef struct packed {
    logic signed [svr_pkg::SmpW-1:0] left;
    logic signed [svr_pkg::SmpW-1:0] right;
  } pair_t;

  typedef struct packed {
    stim_t stim;
    logic  typed;
    pair_t want;
  } dir_row_t;

  typedef enum int {RX_FREE, RX_JITTER, RX_HOLD} rx_pattern_e;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic                             mode;
  logic signed [svr_pkg::SmpW-1:0]  left_in;
  logic signed [svr_pkg::SmpW-1:0]  right_in;
  logic                             coef_bank;
  logic [svr_pkg::SecW-1:0]         coef_section;
  logic [svr_pkg::SlotW-1:0]        coef_slot;
  logic signed [svr_pkg::CoefW-1:0] coef_value;
  logic                             out_valid;
  logic                             out_stall;
  logic signed [svr_pkg::SmpW-1:0]  left_out;
  logic signed [svr_pkg::SmpW-1:0]  right_out;
  logic                             cfg_we;
  logic [svr_pkg::GainW-1:0]        cfg_wdata;

  // model state
  logic signed [svr_pkg::CoefW-1:0] lp_taps  [svr_pkg::CoefPerSec*LowSecs];
  logic signed [svr_pkg::CoefW-1:0] hp_taps  [svr_pkg::CoefPerSec*HighSecs];
  logic signed [svr_pkg::DlyW-1:0]  lp_state [2*svr_pkg::DlyPerSec*LowSecs];
  logic signed [svr_pkg::DlyW-1:0]  hp_state [2*svr_pkg::DlyPerSec*HighSecs];
  logic [svr_pkg::GainW-1:0]        gain_q;
  pair_t                            pending_outputs [$];

  int burst_left;
  int gap;
  int mismatches;
  int results_checked;
  int samples_sent;
  int writes_sent;
  int bad_writes;
  int gain_writes;
  int reloads;
  int idle_cycles;

  stereo_vocal_removal_biquad #(
    .LOW_SECTIONS (LowSecs),
    .HIGH_SECTIONS(HighSecs)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .left_in_i     (left_in),
    .right_in_i    (right_in),
    .coef_bank_i   (coef_bank),
    .coef_section_i(coef_section),
    .coef_slot_i   (coef_slot),
    .coef_value_i  (coef_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .left_out_o    (left_out),
    .right_out_o   (right_out),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint wrap32(input longint v);
    logic signed [svr_pkg::DlyW-1:0] t;
    t = v[svr_pkg::DlyW-1:0];
    return t;
  endfunction

  function automatic logic signed [svr_pkg::SmpW-1:0] clamp16(input longint v);
    if (v > SmpMax) return 16'(SmpMax);
    if (v < SmpMin) return 16'(SmpMin);
    return v[svr_pkg::SmpW-1:0];
  endfunction

  // one channel through one bank; base selects the channel's delay words
  function automatic longint run_biquads(input longint x, input bit hp, input int base);
    longint c [svr_pkg::CoefPerSec];
    longint d0, d1, w, y, acc;
    int     secs, at;
    secs = hp ? HighSecs : LowSecs;
    acc  = x;
    for (int s = 0; s < secs; s++) begin
      for (int k = 0; k < svr_pkg::CoefPerSec; k++) begin
        c[k] = hp ? hp_taps[svr_pkg::CoefPerSec*s+k] : lp_taps[svr_pkg::CoefPerSec*s+k];
      end
      at = base + svr_pkg::DlyPerSec*s;
      d0 = hp ? hp_state[at] : lp_state[at];
      d1 = hp ? hp_state[at+1] : lp_state[at+1];
      w = wrap32(acc - ((c[svr_pkg::SLOT_A1] * d0) >>> svr_pkg::QShift)
                 - ((c[svr_pkg::SLOT_A2] * d1) >>> svr_pkg::QShift));
      y = wrap32(((c[svr_pkg::SLOT_B0] * w) >>> svr_pkg::QShift)
                 + ((c[svr_pkg::SLOT_B1] * d0) >>> svr_pkg::QShift)
                 + ((c[svr_pkg::SLOT_B2] * d1) >>> svr_pkg::QShift));
      if (hp) begin
        hp_state[at+1] = d0[svr_pkg::DlyW-1:0];
        hp_state[at]   = w[svr_pkg::DlyW-1:0];
      end else begin
        lp_state[at+1] = d0[svr_pkg::DlyW-1:0];
        lp_state[at]   = w[svr_pkg::DlyW-1:0];
      end
      acc = y;
    end
    return acc;
  endfunction

  function automatic void process_item(input stim_t it, output bit has_out, output pair_t p);
    logic signed [svr_pkg::SmpW-1:0] l_s, r_s;
    longint lpl, lpr, hpl, hpr, g;
    has_out = 1'b0;
    p       = '0;
    if (it.mode == svr_pkg::MODE_COEF) begin
      if (it.slot <= svr_pkg::SLOT_A2) begin
        if (it.bank == svr_pkg::BANK_LP) begin
          if (it.section < LowSecs) begin
            lp_taps[svr_pkg::CoefPerSec*it.section + it.slot] = it.value;
          end
        end else if (it.section < HighSecs) begin
          hp_taps[svr_pkg::CoefPerSec*it.section + it.slot] = it.value;
        end
      end
    end else begin
      l_s     = it.left;
      r_s     = it.right;
      lpl     = run_biquads(l_s, 1'b0, 0);
      lpr     = run_biquads(r_s, 1'b0, svr_pkg::DlyPerSec*LowSecs);
      hpl     = run_biquads(lpl, 1'b1, 0);
      hpr     = run_biquads(lpr, 1'b1, svr_pkg::DlyPerSec*HighSecs);
      g       = gain_q;
      p.left  = clamp16((hpl - hpr + lpl) * g);
      p.right = clamp16((hpr - hpl + lpr) * g);
      has_out = 1'b1;
    end
  endfunction

  function automatic stim_t pair_item(input int l, input int r);
    stim_t it;
    it.mode    = svr_pkg::MODE_SAMPLE;
    it.left    = 16'(l);
    it.right   = 16'(r);
    it.bank    = 1'($urandom);
    it.section = 3'($urandom);
    it.slot    = 3'($urandom);
    it.value   = 16'($urandom);
    return it;
  endfunction

  function automatic stim_t coef_item(input logic bank, input int sec,
                                      input logic [svr_pkg::SlotW-1:0] slot, input int val);
    stim_t it;
    it.mode    = svr_pkg::MODE_COEF;
    it.left    = 16'($urandom);
    it.right   = 16'($urandom);
    it.bank    = bank;
    it.section = 3'(sec);
    it.slot    = slot;
    it.value   = 16'(val);
    return it;
  endfunction

  function automatic dir_row_t row(input stim_t s, input bit typed, input int el, input int er);
    dir_row_t r;
    r.stim       = s;
    r.typed      = typed;
    r.want.left  = 16'(el);
    r.want.right = 16'(er);
    return r;
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0:       return int'(SmpMax);
      1:       return int'(SmpMin);
      2, 3, 4: return int'($urandom);
      default: return int'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  // mostly tame taps so the cascades stay in range; a few are arbitrary
  function automatic int pick_coef(input logic [svr_pkg::SlotW-1:0] slot);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return int'($urandom);
    if (slot == svr_pkg::SLOT_A1 || slot == svr_pkg::SLOT_A2) begin
      return int'($urandom_range(0, 12000)) - 6000;
    end
    if (r < 3) return int'(SmpMin);
    return int'($urandom_range(0, 48000)) - 24000;
  endfunction

  function automatic stim_t rand_write();
    logic [svr_pkg::SlotW-1:0] slot;
    slot = 3'($urandom);
    return coef_item(1'($urandom), int'($urandom_range(0, 7)), slot, pick_coef(slot));
  endfunction

  function automatic void note_error(input string msg);
    mismatches++;
    if (mismatches <= ReportMax) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  task automatic send_item(input stim_t it, input bit typed, input pair_t want);
    bit    has_out;
    pair_t p;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    mode         = it.mode;
    left_in      = it.left;
    right_in     = it.right;
    coef_bank    = it.bank;
    coef_section = it.section;
    coef_slot    = it.slot;
    coef_value   = it.value;
    in_valid     = 1'b1;
    do @(posedge clk); while (in_stall);
    process_item(it, has_out, p);
    if (has_out) begin
      pending_outputs.push_back(typed ? want : p);
      samples_sent++;
    end else begin
      writes_sent++;
      if (it.slot > svr_pkg::SLOT_A2) bad_writes++;
    end
  endtask

  // hold the sender until every expected pair has come back
  task automatic settle();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_gain(input logic [svr_pkg::GainW-1:0] g);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = g;
    @(negedge clk);
    cfg_we = 1'b0;
    gain_q = g;
    gain_writes++;
  endtask

  // receiver stall pattern
  initial begin
    rx_pattern_e kind;
    int          seg_left;
    out_stall = 1'b0;
    kind      = RX_FREE;
    seg_left  = 0;
    forever begin
      @(negedge clk);
      if (seg_left == 0) begin
        kind = rx_pattern_e'($urandom_range(0, 2));
        if (kind == RX_HOLD) begin
          seg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(230, 320)
                                                 : $urandom_range(1, 20);
        end else begin
          seg_left = $urandom_range(1, 60);
        end
      end
      seg_left--;
      case (kind)
        RX_FREE:   out_stall = 1'b0;
        RX_JITTER: out_stall = 1'($urandom);
        default:   out_stall = 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        note_error($sformatf("unexpected output pair %0d / %0d", left_out, right_out));
      end else begin
        want = pending_outputs.pop_front();
        results_checked++;
        if (left_out !== want.left) begin
          note_error($sformatf("left_out expected %0d got %0d",
                               $signed(want.left), left_out));
        end
        if (right_out !== want.right) begin
          note_error($sformatf("right_out expected %0d got %0d",
                               $signed(want.right), right_out));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: no transfer for %0d cycles", WatchdogLimit);
      $display("stereo_vocal_removal_biquad verification failed");
      $finish;
    end
  end

  initial begin
    dir_row_t                  dir_rows [24];
    stim_t                     it;
    int                        phase, random_items, n, secs;
    logic [svr_pkg::GainW-1:0] g;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    mode            = svr_pkg::MODE_SAMPLE;
    left_in         = '0;
    right_in        = '0;
    coef_bank       = svr_pkg::BANK_LP;
    coef_section    = '0;
    coef_slot       = svr_pkg::SLOT_B0;
    coef_value      = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    burst_left      = 0;
    gap             = 0;
    mismatches      = 0;
    results_checked = 0;
    samples_sent    = 0;
    writes_sent     = 0;
    bad_writes      = 0;
    gain_writes     = 0;
    reloads         = 0;
    idle_cycles     = 0;
    foreach (lp_taps[i]) lp_taps[i] = '0;
    foreach (hp_taps[i]) hp_taps[i] = '0;
    foreach (lp_state[i]) lp_state[i] = '0;
    foreach (hp_state[i]) hp_state[i] = '0;
    gain_q = svr_pkg::GainRst;

    // zero taps give silence; eight b0 = -1.0 sections pass the low bank through exactly
    dir_rows = '{
      row(pair_item(32767, -32768), 1'b1, 0, 0),
      row(pair_item(-32768, 32767), 1'b1, 0, 0),
      row(coef_item(svr_pkg::BANK_LP, 0, 3'(svr_pkg::SLOT_A2 + 1), 32767), 1'b0, 0, 0),
      row(coef_item(svr_pkg::BANK_HP, 7, 3'(svr_pkg::SLOT_A2 + 3), -32768), 1'b0, 0, 0),
      row(pair_item(12345, -1), 1'b1, 0, 0),
      row(coef_item(svr_pkg::BANK_LP, 0, svr_pkg::SLOT_B0, -32768), 1'b0, 0, 0),
      row(coef_item(svr_pkg::BANK_LP, 1, svr_pkg::SLOT_B0, -32768), 1'b0, 0, 0),
      row(coef_item(svr_pkg::BANK_LP, 2, svr_pkg::SLOT_B0, -32768), 1'b0, 0, 0),
      row(coef_item(svr_pkg::BANK_LP, 3, svr_pkg::SLOT_B0, -32768), 1'b0, 0, 0),
      row(coef_item(svr_pkg::BANK_LP, 4, svr_pkg::SLOT_B0, -32768), 1'b0, 0, 0),
      row(coef_item(svr_pkg::BANK_LP, 5, svr_pkg::SLOT_B0, -32768), 1'b0, 0, 0),
      row(coef_item(svr_pkg::BANK_LP, 6, svr_pkg::SLOT_B0, -32768), 1'b0, 0, 0),
      row(coef_item(svr_pkg::BANK_LP, 7, svr_pkg::SLOT_B0, -32768), 1'b0, 0, 0),
      row(pair_item(32767, -32768), 1'b1, 32767, -32768),
      row(pair_item(1, -1), 1'b1, 10, -10),
      row(pair_item(-32768, 32767), 1'b1, -32768, 32767),
      row(coef_item(svr_pkg::BANK_HP, 0, svr_pkg::SLOT_B0, 32767), 1'b0, 0, 0),
      row(coef_item(svr_pkg::BANK_HP, 0, svr_pkg::SLOT_A1, -32768), 1'b0, 0, 0),
      row(coef_item(svr_pkg::BANK_LP, 7, svr_pkg::SLOT_B1, 32767), 1'b0, 0, 0),
      row(coef_item(svr_pkg::BANK_LP, 3, svr_pkg::SLOT_A2, -32768), 1'b0, 0, 0),
      row(coef_item(svr_pkg::BANK_HP, 7, svr_pkg::SLOT_A2, 32767), 1'b0, 0, 0),
      row(pair_item(32767, 32767), 1'b0, 0, 0),
      row(pair_item(-32768, -32768), 1'b0, 0, 0),
      row(pair_item(0, -32768), 1'b0, 0, 0)
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    phase        = 0;
    random_items = $size(dir_rows);
    while (random_items < ItemTarget) begin
      settle();
      case (phase)
        0:       g = '1;
        1:       g = '0;
        2:       g = 8'd1;
        3:       g = svr_pkg::GainRst;
        default: g = ($urandom_range(0, 4) == 0) ? svr_pkg::GainRst : 8'($urandom);
      endcase
      write_gain(g);
      if (phase % 4 == 0 || $urandom_range(0, 3) == 0) begin
        reloads++;
        for (int b = 0; b < 2; b++) begin
          secs = (b == 0) ? LowSecs : HighSecs;
          for (int s = 0; s < secs; s++) begin
            for (int k = 0; k < svr_pkg::CoefPerSec; k++) begin
              it = coef_item(1'(b), s, 3'(k), pick_coef(3'(k)));
              send_item(it, 1'b0, '0);
              random_items++;
            end
          end
        end
      end else begin
        n = $urandom_range(0, 6);
        repeat (n) begin
          it = rand_write();
          send_item(it, 1'b0, '0);
          random_items++;
        end
      end
      n = $urandom_range(15, 60);
      repeat (n) begin
        it = ($urandom_range(0, 11) == 0) ? rand_write() : pair_item(pick_sample(), pick_sample());
        send_item(it, 1'b0, '0);
        random_items++;
      end
      phase++;
    end

    settle();
    $display("covered %0d sample pairs, %0d coefficient writes (%0d bad slot), %0d full reloads",
             samples_sent, writes_sent, bad_writes, reloads);
    $display("%0d gain settings, %0d output pairs compared, %0d mismatches",
             gain_writes, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("stereo_vocal_removal_biquad verification clean");
    end else begin
      $display("stereo_vocal_removal_biquad verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/svr_pkg.sv
rtl/core/svr_ram.sv
rtl/core/svr_dp.sv
rtl/core/svr_ctrl.sv
rtl/core/stereo_vocal_removal_biquad.sv
rtl/core/svr_chk.sv
tb/sv/tb_stereo_vocal_removal_biquad.sv
